// ===== design/case_insensitive_substring_matcher_macros.svh =====
// Assertion macros shared by the matcher checker
`ifndef CASE_INSENSITIVE_SUBSTRING_MATCHER_MACROS_SVH
`define CASE_INSENSITIVE_SUBSTRING_MATCHER_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define CSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define CSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/csm_pkg.sv =====
// Shared types, constants and helpers for the substring matcher
package csm_pkg;

  localparam int MAX_PATTERN   = 32;
  localparam int POSITION_BITS = 24;
  localparam int BYTE_W        = 8;
  localparam int PAT_W         = MAX_PATTERN * BYTE_W;
  localparam int FILL_W        = $clog2(MAX_PATTERN + 1);
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int WORD_BYTES    = CFG_DATA_W / BYTE_W;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

  // Result kinds
  localparam logic RESULT_MATCH   = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_WORD_0 = 3'd0,
    REG_PATTERN_WORD_1 = 3'd1,
    REG_PATTERN_WORD_2 = 3'd2,
    REG_PATTERN_WORD_3 = 3'd3,
    REG_PATTERN_LENGTH = 3'd4
  } cfg_reg_t;

  // Back-end sequencing: first result of an entry, or pending summary
  typedef enum logic {
    BK_FIRST,
    BK_SUMMARY
  } back_state_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic                     hit;
    logic                     last;
    logic                     pos_ovf;
    logic [POSITION_BITS-1:0] end_pos;
  } csm_item_t;

  // Queue status seen by its two sides
  typedef struct packed {
    logic full;
    logic nonempty;
  } csm_queue_status_t;

  // Fold upper-case ASCII letters to lower case
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== design/case_insensitive_substring_matcher.sv =====
// Case-insensitive streaming substring matcher, top level.
//
// Input channel: one text byte per beat (in_text_byte, in_final_byte) under
// in_valid / in_stall. Output channel: one result per beat under out_valid /
// out_stall. A match result carries start, end (one past) and ordinal; the
// byte marked final adds a summary with the text length and total count,
// after which position, count and overflow restart from zero.
// Configuration: cfg_we with cfg_index 0..3 loads pattern words, index 4 the
// pattern length (0 disables matching); write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low; a final byte that also
// completes a match yields a match and then a summary from the back end, which
// emits one result per cycle while out_stall does not hold it. A result passes
// through the queue write, then the output register load. The front compares
// the whole 32-byte window combinationally; a two-entry queue lets the front
// keep accepting while the back waits.
// Reset (rst_n low, synchronous) clears pattern, length and all stream state.
// While out_stall is high the result is held and the queue fills; in_stall
// rises once the queue is full.
module case_insensitive_substring_matcher import csm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_text_byte,
  input  logic                     in_final_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_result_kind,
  output logic [POSITION_BITS-1:0] out_match_start,
  output logic [POSITION_BITS-1:0] out_match_end,
  output logic [POSITION_BITS-1:0] out_match_ordinal,
  output logic                     out_position_overflow,
  output logic                     out_run_last
);

  csm_queue_status_t q_status;
  csm_item_t         push_item;
  csm_item_t         head;
  logic              push;
  logic              pop;
  logic [FILL_W-1:0] pat_len;

  csm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item),
    .pat_len       (pat_len)
  );

  csm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  csm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_status              (q_status),
    .head                  (head),
    .pat_len               (pat_len),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_kind       (out_result_kind),
    .out_match_start       (out_match_start),
    .out_match_end         (out_match_end),
    .out_match_ordinal     (out_match_ordinal),
    .out_position_overflow (out_position_overflow),
    .out_run_last          (out_run_last)
  );

endmodule

// ===== design/csm_front.sv =====
// Front end: pattern registers, byte window, position tracking and match detection
module csm_front import csm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_text_byte,
  input  logic                     in_final_byte,
  input  csm_queue_status_t        q_status,
  output logic                     push,
  output csm_item_t                push_item,
  output logic [FILL_W-1:0]        pat_len
);

  logic [PAT_W-1:0]         pat_r;
  logic [FILL_W-1:0]        len_r;
  logic [PAT_W-1:0]         win_r;
  logic [PAT_W-1:0]         win_nxt;
  logic [FILL_W-1:0]        fill_r;
  logic [FILL_W-1:0]        fill_nxt;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic                     povf_r;
  logic                     povf_nxt;
  logic [CFG_DATA_W-1:0]    word_folded;
  logic [PAT_W-1:0]         pat_rev;
  logic [PAT_W-1:0]         pat_aligned;
  logic [FILL_W-1:0]        align_sh;
  logic [MAX_PATTERN-1:0]   byte_ok;
  logic                     len_ok;
  logic                     accept;

  assign accept   = in_valid && !q_status.full;
  assign in_stall = q_status.full;
  assign pat_len  = len_r;

  // Fold each byte of a pattern word as it is written
  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      word_folded[i*BYTE_W +: BYTE_W] = fold_byte(cfg_wdata[i*BYTE_W +: BYTE_W]);
    end
  end

  // Take configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_WORD_0: pat_r[0*CFG_DATA_W +: CFG_DATA_W] <= word_folded;
        REG_PATTERN_WORD_1: pat_r[1*CFG_DATA_W +: CFG_DATA_W] <= word_folded;
        REG_PATTERN_WORD_2: pat_r[2*CFG_DATA_W +: CFG_DATA_W] <= word_folded;
        REG_PATTERN_WORD_3: pat_r[3*CFG_DATA_W +: CFG_DATA_W] <= word_folded;
        REG_PATTERN_LENGTH: len_r <= cfg_wdata[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  // Shift the new byte into the window, newest at byte 0
  assign win_nxt = {win_r[PAT_W-BYTE_W-1:0], fold_byte(in_text_byte)};

  // Advance fill and position, saturating
  always_comb begin
    fill_nxt = (fill_r < FILL_W'(MAX_PATTERN)) ? fill_r + 1'b1 : fill_r;
    if (pos_r == POS_MAX) begin
      pos_nxt  = pos_r;
      povf_nxt = 1'b1;
    end else begin
      pos_nxt  = pos_r + 1'b1;
      povf_nxt = povf_r;
    end
  end

  // Reverse the pattern, then align its last byte with window byte 0
  always_comb begin
    for (int m = 0; m < MAX_PATTERN; m++) begin
      pat_rev[m*BYTE_W +: BYTE_W] = pat_r[(MAX_PATTERN-1-m)*BYTE_W +: BYTE_W];
    end
  end

  assign align_sh    = FILL_W'(MAX_PATTERN) - len_r;
  assign pat_aligned = pat_rev >> {align_sh, 3'b000};

  // Compare every window byte in parallel; bytes past the length always pass
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      byte_ok[k] = (FILL_W'(k) >= len_r) ||
                   (win_nxt[k*BYTE_W +: BYTE_W] == pat_aligned[k*BYTE_W +: BYTE_W]);
    end
  end

  assign len_ok = (len_r != '0) && (len_r <= FILL_W'(MAX_PATTERN)) && (fill_nxt >= len_r);

  // Hand the classified beat to the queue
  assign push              = accept;
  assign push_item.hit     = len_ok && (&byte_ok);
  assign push_item.last    = in_final_byte;
  assign push_item.pos_ovf = povf_nxt;
  assign push_item.end_pos = pos_nxt;

  // Update stream state; a final byte restarts it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pos_r  <= '0;
      povf_r <= 1'b0;
    end else if (accept) begin
      if (in_final_byte) begin
        fill_r <= '0;
        pos_r  <= '0;
        povf_r <= 1'b0;
      end else begin
        fill_r <= fill_nxt;
        pos_r  <= pos_nxt;
        povf_r <= povf_nxt;
      end
    end
  end

  // Window contents beyond the fill count never take part in a compare
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ===== design/csm_queue.sv =====
// Short queue between front and back ends
module csm_queue import csm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csm_item_t         push_item,
  input  logic              pop,
  output csm_item_t         head,
  output csm_queue_status_t status
);

  csm_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign status.full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign status.nonempty = (cnt_r != '0);
  assign do_push         = push && !status.full;
  assign do_pop          = pop && status.nonempty;
  assign head            = mem_r[rd_ptr_r];

  // Store incoming beats
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/csm_back.sv =====
// Back end: match counting and result generation into the output register
module csm_back import csm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  csm_queue_status_t        q_status,
  input  csm_item_t                head,
  input  logic [FILL_W-1:0]        pat_len,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_result_kind,
  output logic [POSITION_BITS-1:0] out_match_start,
  output logic [POSITION_BITS-1:0] out_match_end,
  output logic [POSITION_BITS-1:0] out_match_ordinal,
  output logic                     out_position_overflow,
  output logic                     out_run_last
);

  back_state_t              state_r;
  back_state_t              state_nxt;
  logic [POSITION_BITS-1:0] cnt_r;
  logic [POSITION_BITS-1:0] cnt_nxt;
  logic                     covf_r;
  logic                     covf_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic                     kind_r;
  logic                     kind_nxt;
  logic [POSITION_BITS-1:0] start_r;
  logic [POSITION_BITS-1:0] start_nxt;
  logic [POSITION_BITS-1:0] end_r;
  logic [POSITION_BITS-1:0] end_nxt;
  logic [POSITION_BITS-1:0] ord_r;
  logic [POSITION_BITS-1:0] ord_nxt;
  logic                     ovf_r;
  logic                     ovf_nxt;
  logic                     last_r;
  logic                     last_nxt;
  logic                     out_free;
  logic                     work;
  logic                     load;
  logic                     cnt_sat;

  assign out_free = !out_valid_r || !out_stall;
  assign work     = q_status.nonempty && out_free;
  assign cnt_sat  = (cnt_r == POS_MAX);

  // Next state: a match on a final byte leaves a summary pending
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_FIRST: begin
        if (work && head.hit && head.last) begin
          state_nxt = BK_SUMMARY;
        end
      end
      BK_SUMMARY: begin
        if (work) begin
          state_nxt = BK_FIRST;
        end
      end
      default: state_nxt = BK_FIRST;
    endcase
  end

  // Outputs: build the next result, count matches, pop finished entries
  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    cnt_nxt   = cnt_r;
    covf_nxt  = covf_r;
    kind_nxt  = RESULT_MATCH;
    start_nxt = head.end_pos - POSITION_BITS'(pat_len);
    end_nxt   = head.end_pos;
    ord_nxt   = cnt_r;
    ovf_nxt   = head.pos_ovf | covf_r;
    last_nxt  = 1'b1;
    unique case (state_r)
      BK_FIRST: begin
        if (work) begin
          if (head.hit) begin
            load     = 1'b1;
            cnt_nxt  = cnt_sat ? cnt_r : cnt_r + 1'b1;
            covf_nxt = covf_r | cnt_sat;
            ovf_nxt  = head.pos_ovf | covf_r | cnt_sat;
            last_nxt = !head.last;
            pop      = !head.last;
          end else if (head.last) begin
            load      = 1'b1;
            kind_nxt  = RESULT_SUMMARY;
            start_nxt = '0;
            pop       = 1'b1;
            cnt_nxt   = '0;
            covf_nxt  = 1'b0;
          end else begin
            pop = 1'b1;
          end
        end
      end
      BK_SUMMARY: begin
        if (work) begin
          load      = 1'b1;
          kind_nxt  = RESULT_SUMMARY;
          start_nxt = '0;
          pop       = 1'b1;
          cnt_nxt   = '0;
          covf_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
    out_valid_nxt = out_free ? load : out_valid_r;
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FIRST;
      cnt_r       <= '0;
      covf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      covf_r      <= covf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output payload when a new result goes out
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      ord_r   <= ord_nxt;
      ovf_r   <= ovf_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = kind_r;
  assign out_match_start       = start_r;
  assign out_match_end         = end_r;
  assign out_match_ordinal     = ord_r;
  assign out_position_overflow = ovf_r;
  assign out_run_last          = last_r;

endmodule

// ===== design/csm_checker.sv =====
// Port-level checker for the matcher, bound to the top level
`include "case_insensitive_substring_matcher_macros.svh"

module csm_checker import csm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_result_kind,
  input logic [POSITION_BITS-1:0] out_match_start,
  input logic [POSITION_BITS-1:0] out_match_end,
  input logic [POSITION_BITS-1:0] out_match_ordinal,
  input logic                     out_run_last
);

  // Hold a stalled result beat
  `CSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_match_end) && $stable(out_match_ordinal) &&
    $stable(out_result_kind), "stalled result beat changed")

  // Mark every summary beat as the last of its run
  `CSM_ASSERT_NOW(a_summary_last, out_valid && out_result_kind == RESULT_SUMMARY,
    out_run_last, "summary beat not marked last")

  // Start a summary at offset zero
  `CSM_ASSERT_NOW(a_summary_start, out_valid && out_result_kind == RESULT_SUMMARY,
    out_match_start == '0, "summary beat with nonzero start")

  // Keep a match start at or below its end
  `CSM_ASSERT_NOW(a_match_order, out_valid && out_result_kind == RESULT_MATCH,
    out_match_start <= out_match_end, "match start beyond match end")

endmodule

bind case_insensitive_substring_matcher csm_checker u_checker (.*);
